FILE: hw/rtl/macr_pkg.sv
// ----------------------------------------------------------------------------
// macr_pkg: shared types and constants
// Words, commands, decision codes and widths for the alpha coverage rescaler.
// ----------------------------------------------------------------------------
package macr_pkg;

    localparam int CNT_W = 25;
    localparam logic [CNT_W-1:0] CNT_MAX = 25'd16777216;
    localparam int BINS = 256;

    typedef enum logic [1:0] {
        CMD_BASE  = 2'd0,
        CMD_HIST  = 2'd1,
        CMD_APPLY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DEC_SKIP    = 2'd0,
        DEC_KEEP    = 2'd1,
        DEC_RESCALE = 2'd2
    } decision_t;

    typedef enum logic {
        KIND_PIXEL  = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] alpha_in;
        logic       last_pixel;
    } in_word_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] alpha_out;
        logic [1:0] decision;
    } out_word_t;

    // queue entry between front and back
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] alpha;
        logic       last;
        logic       first;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HIST_RD,
        ST_HIST_WR,
        ST_PM,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_SCAN,
        ST_APPLY_MUL,
        ST_APPLY_DIV,
        ST_OUT
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v >= CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

FILE: hw/rtl/mip_alpha_coverage_rescaler_core.sv
// ----------------------------------------------------------------------------
// mip_alpha_coverage_rescaler_core: alpha coverage rescaler top level
// Front classifier, job queue and back execution unit.
// ----------------------------------------------------------------------------
// In the back unit a base pass word is counted as it is taken from the queue,
// and a histogram word reads and then writes its bin. The last histogram word
// adds the level decision: a sum of the bins at and above the cutoff, the
// products and the keep test, a bit-serial target division and a threshold
// scan down the histogram memory's one read port. Apply words pass through the
// bit-serial rescale divider while rescaling and go straight out otherwise. A
// four-word queue lets input be taken while the back unit works or a result
// waits. Histogram bins carry valid bits cleared at pass start, so no
// clearing pass is needed.
module mip_alpha_coverage_rescaler_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  macr_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output macr_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);
    import macr_pkg::*;

    logic       q_push, q_full, q_pop, q_nonempty;
    job_t       q_job, q_head;
    logic [7:0] cutoff_reg;

    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cutoff_reg <= 8'd128;
        else if (cfg_valid)
            cutoff_reg <= cfg_data;
    end

    macr_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .q_push(q_push), .q_job(q_job), .q_full(q_full)
    );

    macr_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_job(q_job),
        .full(q_full), .pop(q_pop), .nonempty(q_nonempty), .head(q_head)
    );

    macr_back u_back (
        .clk(clk), .rst_n(rst_n), .cutoff(cutoff_reg), .q_nonempty(q_nonempty),
        .q_head(q_head), .q_pop(q_pop), .out_valid(out_valid),
        .out_ready(out_ready), .out_data(out_data)
    );

    // no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !q_push)
        else $error("push into full queue");
    // no pop from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_nonempty)
        else $error("pop from empty queue");
    // pixel results carry decision zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.result_kind == KIND_PIXEL) |-> out_data.decision == DEC_SKIP)
        else $error("pixel result with decision");

endmodule

FILE: hw/rtl/macr_front.sv
// ----------------------------------------------------------------------------
// macr_front: input classification
// Accepts input words, drops unused commands, tags pass starts, fills queue.
// ----------------------------------------------------------------------------
module macr_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  macr_pkg::in_word_t in_data,
    output logic               q_push,
    output macr_pkg::job_t     q_job,
    input  logic               q_full
);
    import macr_pkg::*;

    logic base_open_reg, base_open_next;
    logic mip_open_reg, mip_open_next;
    logic acc;

    assign in_ready = !q_full;
    assign acc = in_valid && in_ready;

    // classify and tag first pixel of each pass
    always_comb
    begin
        base_open_next = base_open_reg;
        mip_open_next  = mip_open_reg;
        q_push         = 1'b0;
        q_job.cmd      = cmd_t'(in_data.cmd);
        q_job.alpha    = in_data.alpha_in;
        q_job.last     = in_data.last_pixel;
        q_job.first    = 1'b0;
        if (acc)
        begin
            case (cmd_t'(in_data.cmd))
                CMD_BASE:
                begin
                    q_push = 1'b1;
                    q_job.first = !base_open_reg;
                    base_open_next = !in_data.last_pixel;
                end
                CMD_HIST:
                begin
                    q_push = 1'b1;
                    q_job.first = !mip_open_reg;
                    mip_open_next = !in_data.last_pixel;
                end
                CMD_APPLY: q_push = 1'b1;
                default:   q_push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_open_reg <= 1'b0;
            mip_open_reg  <= 1'b0;
        end
        else
        begin
            base_open_reg <= base_open_next;
            mip_open_reg  <= mip_open_next;
        end
    end

endmodule

FILE: hw/rtl/macr_queue.sv
// ----------------------------------------------------------------------------
// macr_queue: job queue
// Four-entry FIFO between front and back.
// ----------------------------------------------------------------------------
module macr_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  macr_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           nonempty,
    output macr_pkg::job_t head
);
    import macr_pkg::*;

    job_t       mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full     = cnt_reg[2];
    assign nonempty = cnt_reg != 3'd0;
    assign head     = mem_reg[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_job;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

endmodule

FILE: hw/rtl/macr_back.sv
// ----------------------------------------------------------------------------
// macr_back: pass execution
// Counts, histogram updates, level decision and pixel rescale.
// ----------------------------------------------------------------------------
module macr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          cutoff,
    input  logic                q_nonempty,
    input  macr_pkg::job_t      q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output macr_pkg::out_word_t out_data
);
    import macr_pkg::*;

    localparam int PW = 33 + CNT_W;  // product width
    localparam int CW = PW + 7;      // width of the scaled tolerance compare
    localparam int SW = 64;          // shift register width for dividers

    logic [CNT_W-1:0] hist_mem [BINS];
    logic [CNT_W-1:0] hist_rd_reg;
    logic [BINS-1:0]  hvalid_reg, hvalid_next;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;
    logic [CNT_W-1:0] nb_reg, nb_next, pb_reg, pb_next, nm_reg, nm_next;
    logic [7:0]  thr_reg, thr_next;
    logic        scale_reg, scale_next;
    logic [7:0]  bin_reg, bin_next;
    logic [32:0] pm_reg, pm_next;
    logic [PW-1:0] lhs_reg, lhs_next, rhs_reg, rhs_next, tol_reg, tol_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] quo_reg, quo_next;
    logic [SW-1:0] dvs_reg, dvs_next;
    logic [5:0]  it_reg, it_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;
    logic        hwr;
    logic [7:0]  haddr;
    logic [CNT_W-1:0] hwdata;
    logic [7:0]  cuse;
    logic [CNT_W-1:0] hval;
    logic [PW-1:0] diff;
    logic [SW-1:0] trial;

    assign cuse = (cutoff == 8'd0) ? 8'd1 : cutoff;
    assign hval = hvalid_reg[bin_reg] ? hist_rd_reg : '0;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign diff  = (lhs_reg >= rhs_reg) ? lhs_reg - rhs_reg : rhs_reg - lhs_reg;
    assign trial = {rem_reg[SW-2:0], quo_reg[SW-1]};

    // histogram memory, registered read, write-first on a same-bin access
    always_ff @(posedge clk)
    begin
        if (hwr)
            hist_mem[haddr] <= hwdata;
        hist_rd_reg <= (hwr && haddr == bin_next) ? hwdata : hist_mem[bin_next];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_nonempty && !out_valid_reg)
                begin
                    case (q_head.cmd)
                        CMD_BASE:  state_next = ST_IDLE;
                        CMD_HIST:  state_next = ST_HIST_RD;
                        CMD_APPLY: state_next = scale_reg ? ST_APPLY_MUL : ST_OUT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            ST_HIST_RD: state_next = ST_HIST_WR;
            ST_HIST_WR:
                if (!job_reg.last)
                    state_next = ST_IDLE;
                else if (pb_reg == '0 || nb_reg == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_PM;
            ST_PM:  if (bin_reg == 8'd255) state_next = ST_MUL;
            ST_MUL: state_next = ST_CMP;
            ST_CMP: state_next = (CW'(diff) * CW'(100) <= CW'(tol_reg) * CW'(3))
                                 ? ST_OUT : ST_DIV;
            ST_DIV: if (it_reg == 6'd63) state_next = ST_SCAN;
            ST_SCAN: if (bin_reg == 8'd1 ||
                         {31'd0, pm_reg + {8'd0, hval}} >= quo_reg)
                         state_next = ST_OUT;
            ST_APPLY_MUL: state_next = ST_APPLY_DIV;
            ST_APPLY_DIV: if (it_reg == 6'd63) state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        job_next = job_reg;
        nb_next = nb_reg; pb_next = pb_reg; nm_next = nm_reg;
        thr_next = thr_reg; scale_next = scale_reg;
        bin_next = bin_reg; pm_next = pm_reg;
        lhs_next = lhs_reg; rhs_next = rhs_reg; tol_next = tol_reg;
        rem_next = rem_reg; quo_next = quo_reg; dvs_next = dvs_reg;
        it_next = it_reg; hvalid_next = hvalid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next = out_reg;
        q_pop = 1'b0; hwr = 1'b0; haddr = bin_reg; hwdata = '0;
        case (state_reg)
            ST_IDLE:
                if (q_nonempty && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    job_next = q_head;
                    bin_next = q_head.alpha;
                    if (q_head.cmd == CMD_BASE)
                    begin
                        nb_next = sat_inc(q_head.first ? '0 : nb_reg);
                        pb_next = q_head.first ? '0 : pb_reg;
                        if (q_head.alpha >= cuse)
                            pb_next = sat_inc(pb_next);
                    end
                    else if (q_head.cmd == CMD_HIST && q_head.first)
                    begin
                        hvalid_next = '0;
                        nm_next = '0;
                        scale_next = 1'b0;
                    end
                    else if (q_head.cmd == CMD_APPLY)
                    begin
                        out_next.result_kind = KIND_PIXEL;
                        out_next.alpha_out = q_head.alpha;
                        out_next.decision = DEC_SKIP;
                    end
                end
            ST_HIST_WR:
            begin
                hwr = 1'b1;
                hwdata = sat_inc(hval);
                hvalid_next[bin_reg] = 1'b1;
                nm_next = sat_inc(nm_reg);
                out_next.result_kind = KIND_STATUS;
                out_next.alpha_out = 8'd0;
                out_next.decision = DEC_SKIP;
                bin_next = cuse;
                pm_next = '0;
                if (job_reg.last)
                    scale_next = 1'b0;
            end
            ST_PM:
            begin
                pm_next = pm_reg + {8'd0, hval};
                bin_next = bin_reg + 8'd1;
            end
            ST_MUL:
            begin
                lhs_next = PW'(pm_reg) * PW'(nb_reg);
                rhs_next = PW'(pb_reg) * PW'(nm_reg);
                tol_next = PW'(nm_reg) * PW'(nb_reg);
            end
            ST_CMP:
            begin
                out_next.decision = DEC_KEEP;
                // ceil(rhs/nb) by restoring division
                quo_next = SW'(rhs_reg) + SW'(nb_reg) - 1'b1;
                rem_next = '0;
                dvs_next = SW'(nb_reg);
                it_next = '0;
            end
            ST_DIV, ST_APPLY_DIV:
            begin
                it_next = it_reg + 6'd1;
                if (trial >= dvs_reg)
                begin
                    rem_next = trial - dvs_reg;
                    quo_next = {quo_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[SW-2:0], 1'b0};
                end
                if (state_reg == ST_DIV && it_reg == 6'd63)
                begin
                    if (quo_next == '0)
                        quo_next = SW'(1);
                    bin_next = 8'd255;
                    pm_next = '0;
                end
                if (state_reg == ST_APPLY_DIV && it_reg == 6'd63)
                    out_next.alpha_out = (quo_next > SW'(255)) ? 8'd255
                                         : quo_next[7:0];
            end
            ST_SCAN:
            begin
                // pm holds running sum of bins above bin_reg
                pm_next = pm_reg + {8'd0, hval};
                if ({31'd0, pm_next} >= quo_reg || bin_reg == 8'd1)
                begin
                    thr_next = ({31'd0, pm_next} >= quo_reg) ? bin_reg : 8'd1;
                    scale_next = 1'b1;
                    out_next.alpha_out = thr_next;
                    out_next.decision = DEC_RESCALE;
                end
                else
                    bin_next = bin_reg - 8'd1;
            end
            ST_APPLY_MUL:
            begin
                quo_next = SW'(job_reg.alpha) * SW'({cuse, 2'b01})
                           + SW'({(thr_reg == 8'd0) ? 8'd1 : thr_reg, 1'b0});
                dvs_next = SW'({(thr_reg == 8'd0) ? 8'd1 : thr_reg, 2'b00});
                rem_next = '0;
                it_next = '0;
            end
            ST_OUT: out_valid_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nb_reg <= '0; pb_reg <= '0; nm_reg <= '0;
            thr_reg <= 8'd1; scale_reg <= 1'b0;
            hvalid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nb_reg <= nb_next; pb_reg <= pb_next; nm_reg <= nm_next;
            thr_reg <= thr_next; scale_reg <= scale_next;
            hvalid_reg <= hvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        job_reg <= job_next; bin_reg <= bin_next; pm_reg <= pm_next;
        lhs_reg <= lhs_next; rhs_reg <= rhs_next; tol_reg <= tol_next;
        rem_reg <= rem_next; quo_reg <= quo_next; dvs_reg <= dvs_next;
        it_reg <= it_next; out_reg <= out_next;
    end

endmodule
